/* rtl/i2c_rts_pkg.sv */
package i2c_rts_pkg;

  localparam int unsigned MAX_BYTES = 256;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_SCAN = 2'd2;
  localparam logic [1:0] MODE_RESP = 2'd3;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_STOP = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_RSTART = 3'd3;
  localparam logic [2:0] OP_ADDR_W = 3'd4;
  localparam logic [2:0] OP_ADDR_R = 3'd5;
  localparam logic [2:0] OP_DATA_W = 3'd6;
  localparam logic [2:0] OP_READ = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_CFG = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_ADDR_NACK = 3'd3;
  localparam logic [2:0] ST_BAD_REG = 3'd4;
  localparam logic [2:0] ST_RSTART_NACK = 3'd5;
  localparam logic [2:0] ST_BAD_XFER = 3'd6;
  localparam logic [2:0] ST_BUS_FAULT = 3'd7;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [8:0] byte_count;
    logic [7:0] write_byte;
    logic       acked;
    logic [7:0] read_byte;
    logic       bus_fault;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] bus_op;
    logic [7:0] frame_byte;
    logic       send_ack;
    logic [7:0] read_data;
    logic       read_valid;
    logic [6:0] scan_address;
    logic       scan_present;
    logic [2:0] status;
    logic       done_res;
  } out_beat_t;

  typedef struct packed {
    logic is_resp;
    logic is_scan;
    logic arg_bad;
  } cls_t;

  typedef struct packed {
    cls_t     cls;
    in_beat_t beat;
  } q_entry_t;

endpackage

/* rtl/i2c_rts_front.sv */
module i2c_rts_front
  import i2c_rts_pkg::*;
(
  input  logic     in_valid,
  input  in_beat_t in_beat,
  input  logic     q_full,
  output logic     in_stall,
  output logic     push,
  output q_entry_t push_entry
);

  cls_t cls;

  always_comb begin
    cls.is_resp = (in_beat.mode == MODE_RESP);
    cls.is_scan = (in_beat.mode == MODE_SCAN);
    cls.arg_bad = in_beat.dev_addr[7] || (in_beat.byte_count == '0) ||
                  (32'(in_beat.byte_count) > MAX_BYTES);
  end

  assign in_stall = q_full;
  assign push = in_valid && !q_full;
  assign push_entry = '{cls: cls, beat: in_beat};

endmodule

/* rtl/i2c_rts_queue.sv */
module i2c_rts_queue
  import i2c_rts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* rtl/i2c_rts_back.sv */
module i2c_rts_back
  import i2c_rts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      head_valid,
  input  q_entry_t  head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRESTOP, PH_START, PH_ADDRW, PH_REG, PH_RSTART, PH_ADDRR,
    PH_READ, PH_WDATA, PH_FINAL, PH_S_START, PH_S_ADDR, PH_S_STOP
  } phase_t;

  phase_t     phase, phase_next;
  logic       configured;
  logic [1:0] op_kind, op_kind_next;
  logic [6:0] target_address, target_address_next;
  logic [7:0] target_register, target_register_next;
  logic [8:0] bytes_left, bytes_left_next;
  logic [7:0] probe_index, probe_index_next;
  logic [2:0] pending_status, pending_status_next;
  logic       probe_acked, probe_acked_next;

  out_beat_t  res;
  logic       has_res;
  logic [8:0] bytes_dec;
  in_beat_t   b;

  assign b = head.beat;
  assign pop = head_valid && (!out_valid || !out_stall);
  assign bytes_dec = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;

  always_comb begin
    res = '0;
    has_res = 1'b0;
    phase_next = phase;
    op_kind_next = op_kind;
    target_address_next = target_address;
    target_register_next = target_register;
    bytes_left_next = bytes_left;
    probe_index_next = probe_index;
    pending_status_next = pending_status;
    probe_acked_next = probe_acked;

    if (!head.cls.is_resp) begin
      if (phase == PH_IDLE) begin
        has_res = 1'b1;
        if (!configured) begin
          res.status = ST_NOT_CFG;
          res.done_res = 1'b1;
        end else if (head.cls.is_scan) begin
          op_kind_next = MODE_SCAN;
          probe_index_next = '0;
          probe_acked_next = 1'b0;
          res.bus_op = OP_STOP;
          phase_next = PH_PRESTOP;
        end else if (head.cls.arg_bad) begin
          res.status = ST_INVALID;
          res.done_res = 1'b1;
        end else begin
          op_kind_next = b.mode;
          target_address_next = b.dev_addr[6:0];
          target_register_next = b.reg_addr;
          bytes_left_next = b.byte_count;
          pending_status_next = ST_OK;
          res.bus_op = OP_STOP;
          phase_next = PH_PRESTOP;
        end
      end
    end else if (phase != PH_IDLE) begin
      has_res = 1'b1;
      if (b.bus_fault) begin
        phase_next = PH_IDLE;
        res.status = ST_BUS_FAULT;
        res.done_res = 1'b1;
      end else begin
        unique case (phase)
          PH_PRESTOP: begin
            res.bus_op = OP_START;
            phase_next = (op_kind == MODE_SCAN) ? PH_S_START : PH_START;
          end
          PH_START: begin
            res.bus_op = OP_ADDR_W;
            res.frame_byte = {target_address, 1'b0};
            phase_next = PH_ADDRW;
          end
          PH_ADDRW: begin
            if (!b.acked) begin
              res.bus_op = OP_STOP;
              pending_status_next = ST_ADDR_NACK;
              phase_next = PH_FINAL;
            end else begin
              res.bus_op = OP_DATA_W;
              res.frame_byte = target_register;
              phase_next = PH_REG;
            end
          end
          PH_REG: begin
            if (!b.acked) begin
              res.bus_op = OP_STOP;
              pending_status_next = ST_BAD_REG;
              phase_next = PH_FINAL;
            end else if (op_kind == MODE_READ) begin
              res.bus_op = OP_RSTART;
              phase_next = PH_RSTART;
            end else begin
              res.bus_op = OP_DATA_W;
              res.frame_byte = b.write_byte;
              phase_next = PH_WDATA;
            end
          end
          PH_RSTART: begin
            res.bus_op = OP_ADDR_R;
            res.frame_byte = {target_address, 1'b1};
            phase_next = PH_ADDRR;
          end
          PH_ADDRR: begin
            if (!b.acked) begin
              res.bus_op = OP_STOP;
              pending_status_next = ST_RSTART_NACK;
              phase_next = PH_FINAL;
            end else begin
              res.bus_op = OP_READ;
              res.send_ack = (bytes_left > 9'd1);
              phase_next = PH_READ;
            end
          end
          PH_READ: begin
            if (!b.acked) begin
              res.bus_op = OP_STOP;
              pending_status_next = ST_BAD_XFER;
              phase_next = PH_FINAL;
            end else begin
              res.read_data = b.read_byte;
              res.read_valid = 1'b1;
              bytes_left_next = bytes_dec;
              if (bytes_dec == '0) begin
                res.bus_op = OP_STOP;
                pending_status_next = ST_OK;
                phase_next = PH_FINAL;
              end else begin
                res.bus_op = OP_READ;
                res.send_ack = (bytes_dec > 9'd1);
              end
            end
          end
          PH_WDATA: begin
            if (!b.acked) begin
              res.bus_op = OP_STOP;
              pending_status_next = ST_BAD_XFER;
              phase_next = PH_FINAL;
            end else begin
              bytes_left_next = bytes_dec;
              if (bytes_dec == '0) begin
                res.bus_op = OP_STOP;
                pending_status_next = ST_OK;
                phase_next = PH_FINAL;
              end else begin
                res.bus_op = OP_DATA_W;
                res.frame_byte = b.write_byte;
              end
            end
          end
          PH_FINAL: begin
            res.status = pending_status;
            res.done_res = 1'b1;
            phase_next = PH_IDLE;
          end
          PH_S_START: begin
            res.bus_op = OP_ADDR_W;
            res.frame_byte = {probe_index[6:0], 1'b0};
            phase_next = PH_S_ADDR;
          end
          PH_S_ADDR: begin
            probe_acked_next = b.acked;
            res.bus_op = OP_STOP;
            phase_next = PH_S_STOP;
          end
          PH_S_STOP: begin
            res.scan_address = probe_index[6:0];
            res.scan_present = probe_acked;
            probe_index_next = probe_index + 1'b1;
            if (probe_index_next[7]) begin
              res.done_res = 1'b1;
              res.status = ST_OK;
              phase_next = PH_IDLE;
            end else begin
              res.bus_op = OP_START;
              phase_next = PH_S_START;
            end
          end
          default: begin
            has_res = 1'b0;
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      configured <= 1'b0;
      op_kind <= '0;
      target_address <= '0;
      target_register <= '0;
      bytes_left <= '0;
      probe_index <= '0;
      pending_status <= '0;
      probe_acked <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        configured <= cfg_wr_data;
      end
      if (pop) begin
        phase <= phase_next;
        op_kind <= op_kind_next;
        target_address <= target_address_next;
        target_register <= target_register_next;
        bytes_left <= bytes_left_next;
        probe_index <= probe_index_next;
        pending_status <= pending_status_next;
        probe_acked <= probe_acked_next;
        out_valid <= has_res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (pop && has_res) begin
      out_beat <= res;
    end
  end

endmodule

/* rtl/i2c_register_transaction_sequencer_top.sv */
// I2C master frame sequencer: commands (register read, register write, bus scan) and
// bus engine responses enter on the input channel, and each beat yields at most one
// result naming the next bus operation, a received byte, a scan report or a final
// status. A front stage classifies beats into a four-entry queue and a back stage
// steps the transaction state machine into an output register, so one beat per
// cycle is sustained unless a full queue or out_stall holds the flow; a beat's
// result passes its queue slot and then the output register. Set the configured
// register before issuing commands and only while no transaction is in flight.
module i2c_register_transaction_sequencer_top
  import i2c_rts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic     q_full;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head;

  i2c_rts_front u_front (
    .in_valid   (in_valid),
    .in_beat    (in_beat),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  i2c_rts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  i2c_rts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat)
  );

endmodule
